// ----- hw/rtl/sod_pkg.sv -----
`default_nettype none
package sod_pkg;

    localparam int MAX_BITS   = 8;
    localparam int TABLE_SIZE = 1 << MAX_BITS;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_COMPUTE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    localparam logic [3:0] INPUT_BITS_RESET = 4'd8;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] index;
        logic [7:0] entry_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] result_value;
        logic       success;
    } out_item_t;

    typedef struct packed {
        logic sbox_wr;
        logic rd_in;
        logic ld_idx;
        logic start;
        logic i_zero;
        logic i_one;
        logic i_inc;
        logic a_inc;
        logic t_one;
        logic t_inc;
        logic diff_clr;
        logic diff_rd_d;
        logic diff_inc;
        logic ld_c0;
        logic mark_wr;
        logic ortho_clr;
        logic ortho_wr;
        logic set_success;
        logic out_load_rd;
        logic out_load_cmp;
    } cmd_t;

    typedef struct packed {
        logic i_last;
        logic a_last;
        logic t_last;
        logic under_half;
        logic t_fail;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sbox_ortho_derivative.sv -----
`default_nettype none
// channel  | direction | payload     | handshake
// in       | input     | in_item_t   | in_valid / in_ready
// out      | output    | out_item_t  | out_valid / out_ready
// cfg      | input     | input_bits  | cfg_valid / cfg_ready
// writes keep the block idle; reads and compute results wait in an output register
// a read waits in ST_RD for the registered result table read and a free output register
// compute, for each input difference, clears and fills the difference table, marks the
// outputs whose count differs from the count at zero, then searches the marked set
// reset clears the result table valid bits, success flag and state machine
// a stalled output holds the next read or compute result in its final state
module sbox_ortho_derivative
    import sod_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [3:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    sod_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sod_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action == ACT_READ |=> !in_ready)
        else $error("read transaction did not hold off input");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action == ACT_WRITE |=> in_ready)
        else $error("write transaction stalled input");

    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a pending transaction");

endmodule
`default_nettype wire

// ----- hw/rtl/sod_datapath.sv -----
`default_nettype none
module sod_datapath
    import sod_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_valid,
    input  wire logic [3:0] cfg_data,
    input  wire in_item_t  in_data,
    input  wire cmd_t      cmd,
    output sts_t           sts,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic [3:0]  input_bits_reg;
    logic [3:0]  nb;
    logic [MAX_BITS-1:0] mask;

    logic [MAX_BITS-1:0] i_reg, a_reg, t_reg, idx_reg;
    logic [MAX_BITS-1:0] s0_reg, s1_reg, d;
    logic [MAX_BITS:0]   diff_rdata, c0_reg;
    logic                mark_rdata, mark_now;
    logic [MAX_BITS-1:0] mcount_reg, mcount_next;
    logic [MAX_BITS-1:0] ortho_rdata, ortho_raddr;
    logic                ortho_hit_reg;
    logic [TABLE_SIZE-1:0] ortho_valid_reg;
    logic                success_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic [MAX_BITS-1:0] sbox_mem  [TABLE_SIZE];
    logic [MAX_BITS:0]   diff_mem  [TABLE_SIZE];
    logic                mark_mem  [TABLE_SIZE];
    logic [MAX_BITS-1:0] ortho_mem [TABLE_SIZE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            input_bits_reg <= INPUT_BITS_RESET;
        else if (cfg_valid)
            input_bits_reg <= cfg_data;
    end

    always_comb
    begin
        if (input_bits_reg == 4'd0)
            nb = 4'd1;
        else if (input_bits_reg > 4'(MAX_BITS))
            nb = 4'(MAX_BITS);
        else
            nb = input_bits_reg;
        mask = MAX_BITS'(((MAX_BITS+1)'(1) << nb) - (MAX_BITS+1)'(1));
    end

    // loop counters, read index and difference count at zero
    always_ff @(posedge clk)
    begin
        if (cmd.i_zero)
            i_reg <= '0;
        else if (cmd.i_one)
            i_reg <= MAX_BITS'(1);
        else if (cmd.i_inc)
            i_reg <= i_reg + MAX_BITS'(1);
        if (cmd.start)
            a_reg <= MAX_BITS'(1);
        else if (cmd.a_inc)
            a_reg <= a_reg + MAX_BITS'(1);
        if (cmd.t_one)
            t_reg <= MAX_BITS'(1);
        else if (cmd.t_inc)
            t_reg <= t_reg + MAX_BITS'(1);
        if (cmd.ld_idx)
            idx_reg <= in_data.index;
        if (cmd.ld_c0)
            c0_reg <= diff_rdata;
    end

    // s-box table, two read ports
    always_ff @(posedge clk)
    begin
        if (cmd.sbox_wr)
            sbox_mem[in_data.index] <= in_data.entry_value;
        s0_reg <= sbox_mem[i_reg];
        s1_reg <= sbox_mem[i_reg ^ a_reg];
    end

    assign d = (s0_reg ^ s1_reg) & mask;

    // difference row counts
    always_ff @(posedge clk)
    begin
        if (cmd.diff_clr)
            diff_mem[i_reg] <= '0;
        else if (cmd.diff_inc)
            diff_mem[d] <= diff_rdata + (MAX_BITS+1)'(1);
        diff_rdata <= diff_mem[cmd.diff_rd_d ? d : i_reg];
    end

    assign mark_now    = diff_rdata != c0_reg;
    assign mcount_next = mcount_reg + MAX_BITS'(mark_now);

    always_ff @(posedge clk)
    begin
        if (cmd.mark_wr)
            mark_mem[i_reg] <= mark_now;
        mark_rdata <= mark_mem[i_reg];
        if (cmd.ld_c0)
            mcount_reg <= '0;
        else if (cmd.mark_wr)
            mcount_reg <= mcount_next;
    end

    // result table
    assign ortho_raddr = cmd.rd_in ? in_data.index : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ortho_wr)
            ortho_mem[a_reg] <= t_reg;
        ortho_rdata <= ortho_mem[ortho_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ortho_valid_reg <= '0;
            ortho_hit_reg   <= 1'b0;
            success_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.start || cmd.ortho_clr)
                ortho_valid_reg <= '0;
            else if (cmd.ortho_wr)
                ortho_valid_reg[a_reg] <= 1'b1;
            ortho_hit_reg <= ortho_valid_reg[ortho_raddr];
            if (cmd.start)
                success_reg <= 1'b0;
            else if (cmd.set_success)
                success_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load_rd || cmd.out_load_cmp)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load_rd)
        begin
            out_data_reg.result_value <= ortho_hit_reg ? ortho_rdata : '0;
            out_data_reg.success      <= success_reg;
        end
        else if (cmd.out_load_cmp)
        begin
            out_data_reg.result_value <= '0;
            out_data_reg.success      <= success_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sts.i_last     = i_reg == mask;
    assign sts.a_last     = a_reg == mask;
    assign sts.t_last     = t_reg == mask;
    assign sts.under_half = mcount_next <= (mask >> 1);
    assign sts.t_fail     = mark_rdata && !(^(t_reg & i_reg));
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

// ----- hw/rtl/sod_ctrl.sv -----
`default_nettype none
module sod_ctrl
    import sod_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic [1:0] in_action,
    output logic           in_ready,
    input  wire sts_t      sts,
    output cmd_t           cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_CLR  = 4'd2;
    localparam logic [3:0] ST_X1   = 4'd3;
    localparam logic [3:0] ST_X2   = 4'd4;
    localparam logic [3:0] ST_X3   = 4'd5;
    localparam logic [3:0] ST_M1   = 4'd6;
    localparam logic [3:0] ST_M2   = 4'd7;
    localparam logic [3:0] ST_M3   = 4'd8;
    localparam logic [3:0] ST_M4   = 4'd9;
    localparam logic [3:0] ST_S1   = 4'd10;
    localparam logic [3:0] ST_S2   = 4'd11;
    localparam logic [3:0] ST_DONE = 4'd12;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = state_reg == ST_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.rd_in = 1'b1;
                if (in_valid)
                begin
                    unique case (in_action)
                        ACT_WRITE:   cmd.sbox_wr = 1'b1;
                        ACT_COMPUTE:
                        begin
                            cmd.start  = 1'b1;
                            cmd.i_zero = 1'b1;
                            state_next = ST_CLR;
                        end
                        ACT_READ:
                        begin
                            cmd.ld_idx = 1'b1;
                            state_next = ST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load_rd = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                cmd.diff_clr = 1'b1;
                if (sts.i_last)
                begin
                    cmd.i_zero = 1'b1;
                    state_next = ST_X1;
                end
                else
                    cmd.i_inc = 1'b1;
            end
            ST_X1: state_next = ST_X2;
            ST_X2:
            begin
                cmd.diff_rd_d = 1'b1;
                state_next    = ST_X3;
            end
            ST_X3:
            begin
                cmd.diff_inc = 1'b1;
                if (sts.i_last)
                begin
                    cmd.i_zero = 1'b1;
                    state_next = ST_M1;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_X1;
                end
            end
            ST_M1: state_next = ST_M2;
            ST_M2:
            begin
                cmd.ld_c0  = 1'b1;
                cmd.i_one  = 1'b1;
                state_next = ST_M3;
            end
            ST_M3: state_next = ST_M4;
            ST_M4:
            begin
                cmd.mark_wr = 1'b1;
                if (sts.i_last)
                begin
                    if (sts.under_half)
                    begin
                        cmd.ortho_clr = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        cmd.t_one  = 1'b1;
                        cmd.i_one  = 1'b1;
                        state_next = ST_S1;
                    end
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_M3;
                end
            end
            ST_S1: state_next = ST_S2;
            ST_S2:
            begin
                priority if (sts.t_fail)
                begin
                    if (sts.t_last)
                    begin
                        cmd.ortho_clr = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        cmd.t_inc  = 1'b1;
                        cmd.i_one  = 1'b1;
                        state_next = ST_S1;
                    end
                end
                else if (sts.i_last)
                begin
                    cmd.ortho_wr = 1'b1;
                    if (sts.a_last)
                    begin
                        cmd.set_success = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        cmd.a_inc  = 1'b1;
                        cmd.i_zero = 1'b1;
                        state_next = ST_CLR;
                    end
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_S1;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load_cmp = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire
